// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/ppou_pkg.sv -----
package ppou_pkg;

    localparam int CH_W        = 8;
    localparam int SQ_W        = 2 * CH_W;
    localparam int SUM_W       = 26;
    localparam int SQRT_STEPS  = CH_W;
    localparam int FRONT_STAGES = 3;
    localparam int NUM_STAGES  = FRONT_STAGES + SQRT_STEPS;
    localparam int TABLE_DEPTH = 1 << CH_W;

    localparam logic [SUM_W-1:0] W_RED   = SUM_W'(299);
    localparam logic [SUM_W-1:0] W_GREEN = SUM_W'(587);
    localparam logic [SUM_W-1:0] W_BLUE  = SUM_W'(114);

    localparam logic [CH_W-1:0] CH_MAX = '1;

    typedef enum logic [1:0] {
        OP_INVERT = 2'd0,
        OP_BRIGHT = 2'd1,
        OP_HSP    = 2'd2,
        OP_KEY    = 2'd3
    } op_mode_t;

    typedef enum logic {
        REG_OP_MODE = 1'b0,
        REG_OFFSET  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            frame_end;
        op_mode_t        mode;
    } ppo_pixel_t;

    typedef logic [SUM_W-1:0] hsp_table_t [TABLE_DEPTH];

    // threshold 1000*k*k for each candidate gray level k
    function automatic hsp_table_t hsp_table_init();
        hsp_table_t t;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            t[k] = SUM_W'(1000 * k * k);
        end
        return t;
    endfunction

    localparam hsp_table_t HSP_TABLE = hsp_table_init();

endpackage

// ----- rtl/core/pixel_point_operation_unit.sv -----
// Per-pixel point operation on an RGBA pixel with 8-bit channels, one pixel per clock.
// op_mode (byte address 0) selects invert, brightness (signed offset at byte address 4,
// applied to a channel only when the sum stays strictly inside 0..255), HSP grayscale
// (floor of sqrt((299r^2+587g^2+114b^2)/1000) on all three colours) or green-screen
// keying (alpha cleared when green > red + blue). tdata packs red, green, blue, alpha
// from the low byte up; tlast carries the frame-end flag. Between input transfer and output,
// squares, weights and sum take three stages and the
// gray level is found one bit per stage by eight table-compare stages. A new pixel can
// be taken every cycle; the whole pipeline holds while the output transfer is stalled.
// Write configuration only while no pixel is in flight.
`include "assert_macros.svh"

module pixel_point_operation_unit
    import ppou_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [4*CH_W-1:0]      s_axis_tdata,   // red, green, blue, alpha
    input  logic                   s_axis_tlast,   // frame_end_in

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [4*CH_W-1:0]      m_axis_tdata,   // red, green, blue, alpha
    output logic                   m_axis_tlast    // frame_end_out
);

    localparam int LAST = NUM_STAGES - 1;

    op_mode_t           op_mode_reg;
    logic signed [8:0]  offset_reg;
    reg_index_t         reg_sel;
    logic               cfg_write;

    logic               advance;
    logic               valid_reg [NUM_STAGES];
    ppo_pixel_t         pix_reg   [NUM_STAGES];
    ppo_pixel_t         pix_next;
    ppo_pixel_t         pix_out;

    logic [SQ_W-1:0]    sq_red_reg, sq_green_reg, sq_blue_reg;
    logic [SUM_W-1:0]   wt_red_reg, wt_green_reg, wt_blue_reg;
    logic [SUM_W-1:0]   sum_reg [SQRT_STEPS];
    logic [CH_W-1:0]    k_reg   [SQRT_STEPS-1];

    logic [CH_W-1:0]    k_prev [SQRT_STEPS];
    logic [CH_W-1:0]    k_try  [SQRT_STEPS];
    logic [CH_W-1:0]    k_new  [SQRT_STEPS];

    logic [CH_W-1:0]    in_red, in_green, in_blue, in_alpha;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= OP_INVERT;
            offset_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_OP_MODE: op_mode_reg <= op_mode_t'(pwdata[1:0]);
                REG_OFFSET:  offset_reg  <= signed'(pwdata[8:0]);
                default:     op_mode_reg <= op_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_OP_MODE: prdata = 32'(op_mode_reg);
            REG_OFFSET:  prdata = 32'(unsigned'(offset_reg));
            default:     prdata = '0;
        endcase
    end

    function automatic logic [CH_W-1:0] bright_channel(input logic [CH_W-1:0] c,
                                                       input logic signed [8:0] off);
        logic signed [9:0] s;
        s = signed'({2'b00, c}) + {off[8], off};
        if (s > 10'sd0 && s < 10'sd255)
            return s[CH_W-1:0];
        return c;
    endfunction

    // pipeline moves as one while the output is free
    assign advance       = !valid_reg[LAST] || m_axis_tready;
    assign s_axis_tready = advance;

    assign in_red   = s_axis_tdata[CH_W-1:0];
    assign in_green = s_axis_tdata[2*CH_W-1:CH_W];
    assign in_blue  = s_axis_tdata[3*CH_W-1:2*CH_W];
    assign in_alpha = s_axis_tdata[4*CH_W-1:3*CH_W];

    // stage 0 point operations for every mode but grayscale
    always_comb
    begin
        pix_next.red       = in_red;
        pix_next.green     = in_green;
        pix_next.blue      = in_blue;
        pix_next.alpha     = in_alpha;
        pix_next.frame_end = s_axis_tlast;
        pix_next.mode      = op_mode_reg;
        case (op_mode_reg)
            OP_INVERT:
            begin
                pix_next.red   = CH_MAX - in_red;
                pix_next.green = CH_MAX - in_green;
                pix_next.blue  = CH_MAX - in_blue;
            end
            OP_BRIGHT:
            begin
                pix_next.red   = bright_channel(in_red, offset_reg);
                pix_next.green = bright_channel(in_green, offset_reg);
                pix_next.blue  = bright_channel(in_blue, offset_reg);
            end
            OP_KEY:
            begin
                if ({1'b0, in_green} > ({1'b0, in_red} + {1'b0, in_blue}))
                    pix_next.alpha = '0;
            end
            default:
            begin
                pix_next.alpha = in_alpha;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // gray level, one bit per stage from the top
    always_comb
    begin
        k_prev[0] = '0;
        for (int i = 1; i < SQRT_STEPS; i++)
        begin
            k_prev[i] = k_reg[i-1];
        end
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            k_try[i] = k_prev[i] | (CH_W'(1) << (SQRT_STEPS - 1 - i));
            k_new[i] = (HSP_TABLE[k_try[i]] <= sum_reg[i]) ? k_try[i] : k_prev[i];
        end
        pix_out = pix_reg[LAST-1];
        if (pix_reg[LAST-1].mode == OP_HSP)
        begin
            pix_out.red   = k_new[SQRT_STEPS-1];
            pix_out.green = k_new[SQRT_STEPS-1];
            pix_out.blue  = k_new[SQRT_STEPS-1];
        end
    end

    // front stages: squares, weights, weighted sum; then the gray level stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg[0]   <= pix_next;
            sq_red_reg   <= SQ_W'(in_red) * SQ_W'(in_red);
            sq_green_reg <= SQ_W'(in_green) * SQ_W'(in_green);
            sq_blue_reg  <= SQ_W'(in_blue) * SQ_W'(in_blue);

            pix_reg[1]   <= pix_reg[0];
            wt_red_reg   <= SUM_W'(sq_red_reg) * W_RED;
            wt_green_reg <= SUM_W'(sq_green_reg) * W_GREEN;
            wt_blue_reg  <= SUM_W'(sq_blue_reg) * W_BLUE;

            pix_reg[2]   <= pix_reg[1];
            sum_reg[0]   <= wt_red_reg + wt_green_reg + wt_blue_reg;

            for (int i = 0; i < SQRT_STEPS - 1; i++)
            begin
                k_reg[i]     <= k_new[i];
                sum_reg[i+1] <= sum_reg[i];
            end
            for (int i = FRONT_STAGES; i < LAST; i++)
            begin
                pix_reg[i] <= pix_reg[i-1];
            end
            pix_reg[LAST] <= pix_out;
        end
    end

    assign m_axis_tvalid = valid_reg[LAST];
    assign m_axis_tdata  = {pix_reg[LAST].alpha, pix_reg[LAST].blue,
                            pix_reg[LAST].green, pix_reg[LAST].red};
    assign m_axis_tlast  = pix_reg[LAST].frame_end;

    `ASSERT_NEXT(a_accept_enters, clk, rst_n, s_axis_tvalid && s_axis_tready, valid_reg[0])
    `ASSERT_IMPL(a_gray_equal, clk, rst_n,
        m_axis_tvalid && pix_reg[LAST].mode == OP_HSP,
        m_axis_tdata[7:0] == m_axis_tdata[15:8] && m_axis_tdata[15:8] == m_axis_tdata[23:16])
    `ASSERT_IMPL(a_key_rule, clk, rst_n,
        m_axis_tvalid && pix_reg[LAST].mode == OP_KEY && m_axis_tdata[31:24] != 8'd0,
        {1'b0, m_axis_tdata[15:8]} <= ({1'b0, m_axis_tdata[7:0]} + {1'b0, m_axis_tdata[23:16]}))

endmodule
